### rtl/s2x_pkg.sv
// Shared types, constants and the rule function for the Scale2x/Scale3x upscaler.
package s2x_pkg;

    localparam int PIX_W = 32;
    localparam int CRD_W = 12;
    localparam int CFG_W = 11;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    localparam logic [10:0] HEIGHT_LIMIT = 11'd1024;

    typedef logic [PIX_W-1:0] t_pix;

    // One block job: the 3x3 window, block centre, scale flag and end flags.
    typedef struct packed {
        t_pix [8:0]        win;
        logic [CRD_W-1:0]  cx;
        logic [CRD_W-1:0]  cy;
        logic              f3;
        logic              last_run;
        logic              last_frame;
    } t_job;

    // Pixel k of the block, following the Scale2x/Scale3x rules.
    function automatic t_pix rule_pix(input t_pix [8:0] w, input logic f3,
                                      input logic [3:0] k);
        t_pix a, b, c, d, e, f, g, h, i;
        logic act;
        t_pix r;
        a = w[0]; b = w[1]; c = w[2];
        d = w[3]; e = w[4]; f = w[5];
        g = w[6]; h = w[7]; i = w[8];
        act = (b != h) && (d != f);
        r = e;
        if (f3) begin
            case (k)
                4'd0: if (act && d == b) r = d;
                4'd1: if (act && ((d == b && e != c) || (b == f && e != a))) r = b;
                4'd2: if (act && b == f) r = f;
                4'd3: if (act && ((d == b && e != g) || (d == h && e != a))) r = d;
                4'd5: if (act && ((b == f && e != i) || (h == f && e != c))) r = f;
                4'd6: if (act && d == h) r = d;
                4'd7: if (act && ((d == h && e != i) || (h == f && e != g))) r = h;
                4'd8: if (act && h == f) r = f;
                default: r = e;
            endcase
        end else begin
            case (k)
                4'd0: if (act && d == b) r = d;
                4'd1: if (act && b == f) r = f;
                4'd2: if (act && d == h) r = d;
                4'd3: if (act && h == f) r = f;
                default: r = e;
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/s2x_front.sv
// Front end: line stores, window, counters; issues up to four block jobs per pixel.
module s2x_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int XW = $clog2(MAX_WIDTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_restart,
    input  logic [10:0]          i_width,
    input  logic [10:0]          i_height,
    input  logic                 i_f3,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  s2x_pkg::t_pix        i_pixel,
    output logic                 o_job_valid,
    input  logic                 i_job_stall,
    output s2x_pkg::t_job        o_job
);
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

    s2x_pkg::t_pix r_older [MAX_WIDTH];
    s2x_pkg::t_pix r_newer [MAX_WIDTH];
    s2x_pkg::t_pix r_rd_old, r_rd_new, r_pix;

    logic [11:0] r_x, r_y;
    logic [11:0] n_x, n_y;
    logic [11:0] wd, ht;
    // stage 1 holds pixel and its store read data; stage 2 issues jobs
    logic        r_s1, r_s2;
    logic [11:0] r_px, r_py;
    logic [1:0]  r_k;
    logic [3:0]  r_mask;
    s2x_pkg::t_pix [8:0] r_win;
    logic [11:0] r_jx, r_jy;
    logic        r_lastf;

    always_comb begin
        wd = (i_width == 11'd0) ? 12'd1 :
             ({2'b00, i_width} > MAXW ? MAXW[11:0] : {1'b0, i_width});
        ht = (i_height == 11'd0) ? 12'd1 :
             ({1'b0, i_height} > {1'b0, s2x_pkg::HEIGHT_LIMIT} ?
              {1'b0, s2x_pkg::HEIGHT_LIMIT} : {1'b0, i_height});
    end

    logic        acc;
    logic [11:0] cx, cy;
    logic        s2_done, s2_adv;
    logic [3:0]  mask_c;
    s2x_pkg::t_pix col0, col1, col2;

    assign cx = (r_x >= wd || r_y >= ht) ? 12'd0 : r_x;
    assign cy = (r_x >= wd || r_y >= ht) ? 12'd0 : r_y;

    // job k: 0 main row at x-1, 1 main row at edge, 2 low row at x-1, 3 low row at edge
    always_comb begin
        mask_c[0] = (r_py >= 12'd1) && (r_px >= 12'd1);
        mask_c[1] = (r_py >= 12'd1) && (r_px == wd - 12'd1);
        mask_c[2] = (r_py == ht - 12'd1) && (r_px >= 12'd1);
        mask_c[3] = (r_py == ht - 12'd1) && (r_px == wd - 12'd1);
    end

    logic [3:0] rem_after;
    always_comb begin
        rem_after = r_mask;
        rem_after[r_k] = 1'b0;
        case (r_k)
            2'd0: rem_after[0] = 1'b0;
            2'd1: rem_after[1:0] = 2'b00;
            2'd2: rem_after[2:0] = 3'b000;
            default: rem_after = 4'b0000;
        endcase
    end

    assign s2_done = !r_s2 || (r_mask == 4'b0000) ||
                     (!i_job_stall && rem_after == 4'b0000);
    assign s2_adv  = r_s1 && s2_done;
    assign o_stall = r_s1 && !s2_done;
    assign acc     = i_valid && !o_stall;

    always_comb begin
        if (r_py == 12'd0) begin
            col0 = r_pix; col1 = r_pix;
        end else begin
            col1 = r_rd_new;
            col0 = (r_py >= 12'd2) ? r_rd_old : r_rd_new;
        end
        col2 = r_pix;
    end

    always_comb begin
        n_x = cx + 12'd1;
        n_y = cy;
        if (n_x >= wd) begin
            n_x = 12'd0;
            n_y = cy + 12'd1;
            if (n_y >= ht) n_y = 12'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_old <= r_older[cx[XW-1:0]];
            r_rd_new <= r_newer[cx[XW-1:0]];
            r_older[cx[XW-1:0]] <= r_newer[cx[XW-1:0]];
            r_newer[cx[XW-1:0]] <= i_pixel;
            r_pix <= i_pixel;
            r_px  <= cx;
            r_py  <= cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= 12'd0; r_y <= 12'd0;
            r_s1 <= 1'b0; r_s2 <= 1'b0;
            r_k <= 2'd0; r_mask <= 4'd0;
            r_win <= '0;
        end else begin
            if (i_restart) begin
                r_x <= 12'd0; r_y <= 12'd0;
            end else if (acc) begin
                r_x <= n_x; r_y <= n_y;
            end
            if (s2_adv) begin
                r_s2 <= 1'b1;
                r_mask <= mask_c;
                r_k <= mask_c[0] ? 2'd0 : mask_c[1] ? 2'd1 : mask_c[2] ? 2'd2 : 2'd3;
                r_jx <= r_px;
                r_jy <= r_py;
                r_lastf <= (r_px == wd - 12'd1) && (r_py == ht - 12'd1);
                if (r_px == 12'd0) begin
                    r_win[0] <= col0; r_win[1] <= col0; r_win[2] <= col0;
                    r_win[3] <= col1; r_win[4] <= col1; r_win[5] <= col1;
                    r_win[6] <= col2; r_win[7] <= col2; r_win[8] <= col2;
                end else begin
                    r_win[0] <= r_win[1]; r_win[1] <= r_win[2]; r_win[2] <= col0;
                    r_win[3] <= r_win[4]; r_win[4] <= r_win[5]; r_win[5] <= col1;
                    r_win[6] <= r_win[7]; r_win[7] <= r_win[8]; r_win[8] <= col2;
                end
            end else if (r_s2 && r_mask != 4'b0000 && !i_job_stall) begin
                r_mask <= rem_after;
                r_k <= rem_after[1] ? 2'd1 : rem_after[2] ? 2'd2 : 2'd3;
                if (rem_after == 4'b0000) r_s2 <= 1'b0;
            end else if (r_s2 && r_mask == 4'b0000) begin
                r_s2 <= 1'b0;
            end
            if (acc) r_s1 <= 1'b1;
            else if (s2_adv) r_s1 <= 1'b0;
        end
    end

    // job window from r_win according to job kind
    s2x_pkg::t_pix [8:0] w_main, w_edge, w_low, w_lowedge, w_sel;
    always_comb begin
        w_main = r_win;
        for (int r = 0; r < 3; r++) begin
            w_edge[3*r+0] = r_win[3*r+1];
            w_edge[3*r+1] = r_win[3*r+2];
            w_edge[3*r+2] = r_win[3*r+2];
        end
        for (int c = 0; c < 3; c++) begin
            w_low[c]   = r_win[3+c];
            w_low[3+c] = r_win[6+c];
            w_low[6+c] = r_win[6+c];
        end
        for (int r = 0; r < 3; r++) begin
            w_lowedge[3*r+0] = w_low[3*r+1];
            w_lowedge[3*r+1] = w_low[3*r+2];
            w_lowedge[3*r+2] = w_low[3*r+2];
        end
        case (r_k)
            2'd0: w_sel = w_main;
            2'd1: w_sel = w_edge;
            2'd2: w_sel = w_low;
            default: w_sel = w_lowedge;
        endcase
    end

    assign o_job_valid = r_s2 && (r_mask != 4'b0000);
    always_comb begin
        o_job.win = w_sel;
        o_job.cx  = (r_k[0]) ? wd - 12'd1 : r_jx - 12'd1;
        o_job.cy  = (r_k[1]) ? r_jy : r_jy - 12'd1;
        o_job.f3  = i_f3;
        o_job.last_run   = (rem_after == 4'b0000);
        o_job.last_frame = (rem_after == 4'b0000) && r_lastf;
    end
endmodule

### rtl/s2x_queue.sv
// Short job queue between front and back ends.
module s2x_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  s2x_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_stall,
    output s2x_pkg::t_job o_job
);
    localparam int AW = $clog2(DEPTH);
    s2x_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign wr = i_valid && !o_stall;
    assign rd = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

### rtl/s2x_back.sv
// Back end: walks job blocks, one registered output pixel per cycle unless stalled.
module s2x_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  s2x_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_stall,
    output s2x_pkg::t_pix o_pixel,
    output logic [11:0]   o_x,
    output logic [11:0]   o_y,
    output logic          o_last_run,
    output logic          o_last_frame
);
    logic [3:0] r_k;
    logic [1:0] r_bc, r_br;
    logic       r_ov;
    logic       last_k, out_free, step;
    logic [11:0] bx, by;

    assign out_free = !r_ov || !i_stall;
    assign last_k   = i_job.f3 ? (r_k == 4'd8) : (r_k == 4'd3);
    assign step     = i_valid && out_free;
    assign o_stall  = !(step && last_k);
    assign o_valid  = r_ov;

    // f*c computed as c + c (+ c)
    assign bx = i_job.cx + i_job.cx + (i_job.f3 ? i_job.cx : 12'd0);
    assign by = i_job.cy + i_job.cy + (i_job.f3 ? i_job.cy : 12'd0);

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_pixel      <= s2x_pkg::rule_pix(i_job.win, i_job.f3, r_k);
            o_x          <= bx + {10'd0, r_bc};
            o_y          <= by + {10'd0, r_br};
            o_last_run   <= last_k && i_job.last_run;
            o_last_frame <= last_k && i_job.last_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 4'd0; r_bc <= 2'd0; r_br <= 2'd0; r_ov <= 1'b0;
        end else begin
            if (step) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (step) begin
                if (last_k) begin
                    r_k <= 4'd0; r_bc <= 2'd0; r_br <= 2'd0;
                end else begin
                    r_k <= r_k + 4'd1;
                    if (r_bc == (i_job.f3 ? 2'd2 : 2'd1)) begin
                        r_bc <= 2'd0; r_br <= r_br + 2'd1;
                    end else begin
                        r_bc <= r_bc + 2'd1;
                    end
                end
            end
        end
    end
endmodule

### rtl/scale2x_scale3x_upscaler.sv
// Top level of the Scale2x/Scale3x pixel-art upscaler.
// Input channel: i_valid/o_stall with i_pixel_in, one ARGB pixel per request in raster order.
// Output channel: o_valid/i_stall with pixel, output coordinates and end markers.
// Config channel: i_cfg_valid/o_cfg_ready, index 0 width, 1 height, 2 scale factor;
// any write to a known index restarts the frame at pixel (0,0).
// The front end reads both line stores at once for each pixel and issues up to four block
// jobs; a four-entry queue feeds the back end, which emits one output pixel per cycle
// while it holds a job and the output is not stalled. Each block gives four output
// pixels in Scale2x mode and nine in Scale3x mode; steady state is set by the back end's walk.
// An accepted pixel passes the front end's stage registers, the queue and the back end's output register.
// Row 0 produces nothing unless it is also the last row; the last row and column flush pending blocks.
// Reset clears counters, queue and output valid; registers go to 1x1, Scale2x.
// When the receiver stalls, the output holds, the queue fills, then o_stall rises.
module scale2x_scale3x_upscaler #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel_out,
    output logic [11:0] o_out_x,
    output logic [11:0] o_out_y,
    output logic        o_last_of_run,
    output logic        o_last_of_frame
);
    logic [10:0] r_width, r_height;
    logic [1:0]  r_scale;
    logic        cfg_wr, restart;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign restart = cfg_wr && (i_cfg_index == s2x_pkg::REG_WIDTH ||
                     i_cfg_index == s2x_pkg::REG_HEIGHT || i_cfg_index == s2x_pkg::REG_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd1; r_height <= 11'd1; r_scale <= 2'd2;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                s2x_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                s2x_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                s2x_pkg::REG_SCALE:  r_scale  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic          f_jv, f_js, b_jv, b_js;
    s2x_pkg::t_job f_job, b_job;

    s2x_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_restart(restart),
        .i_width(r_width), .i_height(r_height), .i_f3(r_scale == 2'd3),
        .i_valid, .o_stall, .i_pixel(i_pixel_in),
        .o_job_valid(f_jv), .i_job_stall(f_js), .o_job(f_job)
    );

    s2x_queue #(.DEPTH(4)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_jv), .o_stall(f_js), .i_job(f_job),
        .o_valid(b_jv), .i_stall(b_js), .o_job(b_job)
    );

    s2x_back u_back (
        .i_clk, .i_rst_n, .i_valid(b_jv), .o_stall(b_js), .i_job(b_job),
        .o_valid, .i_stall, .o_pixel(o_pixel_out), .o_x(o_out_x), .o_y(o_out_y),
        .o_last_run(o_last_of_run), .o_last_frame(o_last_of_frame)
    );
endmodule

### rtl/s2x_checker.sv
// Port-level checker for the upscaler, bound to the top level.
module s2x_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_pixel_out,
    input logic        o_last_of_run,
    input logic        o_last_of_frame
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_out))
        else $error("stalled output changed");
    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_frame |-> o_last_of_run)
        else $error("frame end without run end");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind scale2x_scale3x_upscaler s2x_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_pixel_out, .o_last_of_run, .o_last_of_frame
);
